// ===== rtl/mpm_quadratic_stencil_weights_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the quadratic stencil weight block
// Shared wrappers so every checked module writes its properties the same way.
// ----------------------------------------------------------------------------
`ifndef MPM_QUADRATIC_STENCIL_WEIGHTS_MACROS_SVH
`define MPM_QUADRATIC_STENCIL_WEIGHTS_MACROS_SVH

// Same-cycle implication, held off during reset
`define MQSW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset
`define MQSW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mpm_qsw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpm_qsw_pkg
// Types and constants shared by the quadratic B-spline stencil weight block.
// ----------------------------------------------------------------------------
package mpm_qsw_pkg;

    // Q.16 constants used by the B-spline weight terms
    localparam logic [16:0]        Q16_HALF         = 17'd32768;   // 0.5
    localparam logic [16:0]        Q16_ONE          = 17'd65536;   // 1.0
    localparam logic [16:0]        Q16_THREE_HALVES = 17'd98304;   // 1.5
    localparam logic [15:0]        W_MID_PEAK       = 16'd49152;   // 0.75
    localparam logic signed [18:0] Q16_TWO          = 19'sd131072; // 2.0

    // Half a cell in the Q32.32 cell product
    localparam logic signed [63:0] Q32_HALF = 64'sh0000_0000_8000_0000;

    // Node coordinate range
    localparam logic signed [23:0] NODE_MAX = 24'sd8388607;
    localparam logic signed [23:0] NODE_MIN = -24'sd8388608;

    // Gradient saturation range
    localparam logic signed [35:0] GRAD_MAX = 36'sd2147483647;
    localparam logic signed [35:0] GRAD_MIN = -36'sd2147483648;

    // Stencil walk
    localparam logic [1:0] IDX_LAST  = 2'd2;
    localparam logic [4:0] LAST_SLOT = 5'd26;

    localparam logic [31:0] INV_CELL_RESET = 32'd65536;

    // Per-axis setup: base cell, weights (Q0.16), derivatives (Q.16)
    typedef struct packed {
        logic signed [31:0] base;
        logic [2:0][15:0]   w;
        logic [2:0][17:0]   d;
    } axis_t;

    // Bookkeeping that rides along with every stencil entry
    typedef struct packed {
        logic [23:0]        owner;
        logic signed [23:0] node_x;
        logic signed [23:0] node_y;
        logic signed [23:0] node_z;
        logic [4:0]         slot;
        logic               last;
        logic               range_error;
    } tag_t;

    typedef struct packed {
        tag_t               tag;
        logic [15:0]        wx;
        logic [15:0]        wy;
        logic [15:0]        wz;
        logic signed [17:0] dx;
        logic signed [17:0] dy;
        logic signed [17:0] dz;
    } slot_item_t;

    typedef struct packed {
        tag_t               tag;
        logic [15:0]        wx;
        logic [31:0]        m_yz;
        logic [31:0]        m_xz;
        logic [31:0]        m_xy;
        logic signed [17:0] dx;
        logic signed [17:0] dy;
        logic signed [17:0] dz;
    } prod_item_t;

    typedef struct packed {
        tag_t               tag;
        logic [15:0]        weight;
        logic signed [18:0] gx;
        logic signed [18:0] gy;
        logic signed [18:0] gz;
    } grad_item_t;

    typedef struct packed {
        tag_t               tag;
        logic [15:0]        weight;
        logic signed [31:0] grad_x;
        logic signed [31:0] grad_y;
        logic signed [31:0] grad_z;
    } out_item_t;

endpackage

// ===== rtl/mpm_quadratic_stencil_weights.sv =====
`timescale 1ns / 1ps
`include "mpm_quadratic_stencil_weights_macros.svh"
// ----------------------------------------------------------------------------
// mpm_quadratic_stencil_weights
// Quadratic B-spline stencil generator: 27 weighted grid-node entries per
// particle position.
// ----------------------------------------------------------------------------
// Each accepted particle yields 27 result transfers, slot 0 to 26, x fastest,
// then y, then z; last marks slot 26. The slot sequencer emits one entry per
// cycle while the output is not stalled and takes the next particle as it
// issues slot 26, so in a steady unstalled stream the result channel is busy
// every cycle. Two setup stages in front of the sequencer take the next
// particles while the current one is still streaming, so the input stalls only
// when both are full and the sequencer cannot take a particle. The first entry
// of a particle passes the setup stages, the sequencer, the entry register, the
// pair and triple product stages and the output register. inv_cell_size resets
// to 1.0 and must only be written while no particle is in flight.
// ----------------------------------------------------------------------------
module mpm_quadratic_stencil_weights (
    input  logic               clk,
    input  logic               rst_n,
    // Configuration
    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data,
    // Particle input
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [23:0]        particle_id,
    // Stencil output
    output logic               out_valid,
    input  logic               out_stall,
    output logic [23:0]        owner_particle,
    output logic signed [23:0] node_x,
    output logic signed [23:0] node_y,
    output logic signed [23:0] node_z,
    output logic [4:0]         slot,
    output logic [15:0]        weight,
    output logic signed [31:0] grad_x,
    output logic signed [31:0] grad_y,
    output logic signed [31:0] grad_z,
    output logic               range_error,
    output logic               last
);

    logic [31:0] inv_cell_reg, inv_cell_next;

    logic a_valid_reg, a_valid_next;
    logic b_valid_reg, b_valid_next;
    logic ready_a, ready_b;
    logic [23:0] id_a_reg, id_b_reg;

    mpm_qsw_pkg::axis_t setup_x, setup_y, setup_z;

    logic                    seq_src_ready;
    logic                    issue_valid;
    logic                    eval_ready;
    mpm_qsw_pkg::slot_item_t issue_item;
    mpm_qsw_pkg::out_item_t  res;

    // Configuration register
    assign inv_cell_next = cfg_wr_en ? cfg_wr_data : inv_cell_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_cell_reg <= mpm_qsw_pkg::INV_CELL_RESET;
        end
        else
        begin
            inv_cell_reg <= inv_cell_next;
        end
    end

    // Setup stage control
    always_comb
    begin
        ready_b      = !b_valid_reg || seq_src_ready;
        ready_a      = !a_valid_reg || ready_b;
        a_valid_next = ready_a ? in_valid : a_valid_reg;
        b_valid_next = ready_b ? a_valid_reg : b_valid_reg;
    end

    assign in_stall = !ready_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // Particle index follows the setup stages
    always_ff @(posedge clk)
    begin
        if (ready_a)
        begin
            id_a_reg <= particle_id;
        end
        if (ready_b)
        begin
            id_b_reg <= id_a_reg;
        end
    end

    // Per-axis setup
    mpm_qsw_axis u_axis_x (
        .clk           (clk),
        .en_a          (ready_a),
        .en_b          (ready_b),
        .pos           (pos_x),
        .inv_cell_size (inv_cell_reg),
        .setup         (setup_x)
    );

    mpm_qsw_axis u_axis_y (
        .clk           (clk),
        .en_a          (ready_a),
        .en_b          (ready_b),
        .pos           (pos_y),
        .inv_cell_size (inv_cell_reg),
        .setup         (setup_y)
    );

    mpm_qsw_axis u_axis_z (
        .clk           (clk),
        .en_a          (ready_a),
        .en_b          (ready_b),
        .pos           (pos_z),
        .inv_cell_size (inv_cell_reg),
        .setup         (setup_z)
    );

    // Slot walk
    mpm_qsw_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .src_valid   (b_valid_reg),
        .src_ready   (seq_src_ready),
        .src_x       (setup_x),
        .src_y       (setup_y),
        .src_z       (setup_z),
        .src_owner   (id_b_reg),
        .issue_valid (issue_valid),
        .issue_item  (issue_item),
        .dst_ready   (eval_ready)
    );

    // Entry arithmetic and output register
    mpm_qsw_eval u_eval (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (issue_valid),
        .in_ready      (eval_ready),
        .in_item       (issue_item),
        .inv_cell_size (inv_cell_reg),
        .out_valid     (out_valid),
        .out_item      (res),
        .out_stall     (out_stall)
    );

    assign owner_particle = res.tag.owner;
    assign node_x         = res.tag.node_x;
    assign node_y         = res.tag.node_y;
    assign node_z         = res.tag.node_z;
    assign slot           = res.tag.slot;
    assign weight         = res.weight;
    assign grad_x         = res.grad_x;
    assign grad_y         = res.grad_y;
    assign grad_z         = res.grad_z;
    assign range_error    = res.tag.range_error;
    assign last           = res.tag.last;

    // Checks
    `MQSW_ASSERT_NOW(a_last_on_final_slot, clk, rst_n, out_valid && last,
        slot == mpm_qsw_pkg::LAST_SLOT, "last marker not on the final slot")
    `MQSW_ASSERT_NEXT(a_slot_in_order, clk, rst_n, out_valid && !out_stall && !last,
        !out_valid || (slot == $past(slot) + 5'd1), "stencil slot skipped or repeated")
    `MQSW_ASSERT_NEXT(a_restart_at_zero, clk, rst_n, out_valid && !out_stall && last,
        !out_valid || (slot == '0), "new particle does not start at slot zero")

endmodule

// ===== rtl/mpm_qsw_axis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpm_qsw_axis
// Two-stage per-axis setup: cell product, then base cell, fraction,
// quadratic B-spline weights and derivatives.
// ----------------------------------------------------------------------------
module mpm_qsw_axis (
    input  logic                clk,
    input  logic                en_a,
    input  logic                en_b,
    input  logic signed [31:0]  pos,
    input  logic [31:0]         inv_cell_size,
    output mpm_qsw_pkg::axis_t  setup
);

    logic signed [65:0] prod_full;
    logic signed [63:0] prod_next;
    logic signed [63:0] prod_reg;

    logic signed [63:0] q;
    logic [16:0]        f;
    logic [16:0]        t;
    logic signed [17:0] u;
    logic [16:0]        v;
    logic [33:0]        tsq;
    logic signed [35:0] usq;
    logic [33:0]        vsq;
    logic signed [18:0] d1_wide;

    mpm_qsw_pkg::axis_t setup_next;
    mpm_qsw_pkg::axis_t setup_reg;

    // Stage A: exact Q32.32 cell coordinate
    always_comb
    begin
        prod_full = 66'(pos) * 66'($signed({1'b0, inv_cell_size}));
        prod_next = prod_full[63:0];
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            prod_reg <= prod_next;
        end
    end

    // Stage B: base = floor(cell - 0.5), fraction in [0.5, 1.5)
    always_comb
    begin
        q       = prod_reg - mpm_qsw_pkg::Q32_HALF;
        f       = {~prod_reg[31], prod_reg[31:16]};
        t       = mpm_qsw_pkg::Q16_THREE_HALVES - f;
        u       = $signed({1'b0, f}) - $signed({1'b0, mpm_qsw_pkg::Q16_ONE});
        v       = f - mpm_qsw_pkg::Q16_HALF;
        tsq     = 34'(t) * 34'(t);
        usq     = 36'(u) * 36'(u);
        vsq     = 34'(v) * 34'(v);
        d1_wide = mpm_qsw_pkg::Q16_TWO - $signed({1'b0, f, 1'b0});

        setup_next.base = q[63:32];
        setup_next.w[0] = tsq[32:17];
        setup_next.w[1] = mpm_qsw_pkg::W_MID_PEAK - usq[31:16];
        setup_next.w[2] = vsq[32:17];
        setup_next.d[0] = $signed({1'b0, f}) - $signed({1'b0, mpm_qsw_pkg::Q16_THREE_HALVES});
        setup_next.d[1] = d1_wide[17:0];
        setup_next.d[2] = $signed({1'b0, f}) - $signed({1'b0, mpm_qsw_pkg::Q16_HALF});
    end

    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            setup_reg <= setup_next;
        end
    end

    assign setup = setup_reg;

endmodule

// ===== rtl/mpm_qsw_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpm_qsw_seq
// Slot sequencer: holds one particle's axis setups and walks the 27 stencil
// nodes (x fastest, then y, then z), one entry per transfer downstream.
// ----------------------------------------------------------------------------
module mpm_qsw_seq (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     src_valid,
    output logic                     src_ready,
    input  mpm_qsw_pkg::axis_t       src_x,
    input  mpm_qsw_pkg::axis_t       src_y,
    input  mpm_qsw_pkg::axis_t       src_z,
    input  logic [23:0]              src_owner,
    output logic                     issue_valid,
    output mpm_qsw_pkg::slot_item_t  issue_item,
    input  logic                     dst_ready
);

    logic       busy_reg, busy_next;
    logic [1:0] xi_reg, xi_next;
    logic [1:0] yi_reg, yi_next;
    logic [1:0] zi_reg, zi_next;
    logic [4:0] slot_reg, slot_next;

    mpm_qsw_pkg::axis_t cur_x_reg, cur_y_reg, cur_z_reg;
    logic [23:0]        owner_reg;

    logic issue;
    logic finish;
    logic take;

    logic signed [32:0] nx_sum, ny_sum, nz_sum;
    logic [24:0]        nx_cl, ny_cl, nz_cl;

    // Clamp to the 24-bit node range; top bit flags saturation
    function automatic logic [24:0] clamp_node(input logic signed [32:0] v);
        logic [24:0] r;
        if (v > 33'(mpm_qsw_pkg::NODE_MAX))
            r = {1'b1, mpm_qsw_pkg::NODE_MAX};
        else if (v < 33'(mpm_qsw_pkg::NODE_MIN))
            r = {1'b1, mpm_qsw_pkg::NODE_MIN};
        else
            r = {1'b0, v[23:0]};
        return r;
    endfunction

    // Handshake on both sides
    always_comb
    begin
        issue     = busy_reg && dst_ready;
        finish    = issue && (slot_reg == mpm_qsw_pkg::LAST_SLOT);
        src_ready = !busy_reg || finish;
        take      = src_valid && src_ready;
        busy_next = take || (busy_reg && !finish);
    end

    // Slot counters
    always_comb
    begin
        xi_next   = xi_reg;
        yi_next   = yi_reg;
        zi_next   = zi_reg;
        slot_next = slot_reg;
        if (take)
        begin
            xi_next   = '0;
            yi_next   = '0;
            zi_next   = '0;
            slot_next = '0;
        end
        else if (issue)
        begin
            slot_next = slot_reg + 5'd1;
            if (xi_reg == mpm_qsw_pkg::IDX_LAST)
            begin
                xi_next = '0;
                if (yi_reg == mpm_qsw_pkg::IDX_LAST)
                begin
                    yi_next = '0;
                    zi_next = zi_reg + 2'd1;
                end
                else
                begin
                    yi_next = yi_reg + 2'd1;
                end
            end
            else
            begin
                xi_next = xi_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            xi_reg   <= '0;
            yi_reg   <= '0;
            zi_reg   <= '0;
            slot_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            xi_reg   <= xi_next;
            yi_reg   <= yi_next;
            zi_reg   <= zi_next;
            slot_reg <= slot_next;
        end
    end

    // Current particle
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cur_x_reg <= src_x;
            cur_y_reg <= src_y;
            cur_z_reg <= src_z;
            owner_reg <= src_owner;
        end
    end

    // Entry for the current slot
    always_comb
    begin
        nx_sum = 33'(cur_x_reg.base) + {31'b0, xi_reg};
        ny_sum = 33'(cur_y_reg.base) + {31'b0, yi_reg};
        nz_sum = 33'(cur_z_reg.base) + {31'b0, zi_reg};
        nx_cl  = clamp_node(nx_sum);
        ny_cl  = clamp_node(ny_sum);
        nz_cl  = clamp_node(nz_sum);

        issue_item.tag.owner       = owner_reg;
        issue_item.tag.node_x      = nx_cl[23:0];
        issue_item.tag.node_y      = ny_cl[23:0];
        issue_item.tag.node_z      = nz_cl[23:0];
        issue_item.tag.slot        = slot_reg;
        issue_item.tag.last        = (slot_reg == mpm_qsw_pkg::LAST_SLOT);
        issue_item.tag.range_error = nx_cl[24] | ny_cl[24] | nz_cl[24];
        issue_item.wx              = cur_x_reg.w[xi_reg];
        issue_item.wy              = cur_y_reg.w[yi_reg];
        issue_item.wz              = cur_z_reg.w[zi_reg];
        issue_item.dx              = $signed(cur_x_reg.d[xi_reg]);
        issue_item.dy              = $signed(cur_y_reg.d[yi_reg]);
        issue_item.dz              = $signed(cur_z_reg.d[zi_reg]);
    end

    assign issue_valid = busy_reg;

endmodule

// ===== rtl/mpm_qsw_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpm_qsw_eval
// Four-stage entry pipeline: entry register, pair products, triple products
// with floor, gradient scaling with saturation into the output register.
// ----------------------------------------------------------------------------
module mpm_qsw_eval (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  mpm_qsw_pkg::slot_item_t  in_item,
    input  logic [31:0]              inv_cell_size,
    output logic                     out_valid,
    output mpm_qsw_pkg::out_item_t   out_item,
    input  logic                     out_stall
);

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_valid_next, s2_valid_next, s3_valid_next, s4_valid_next;
    logic rdy1, rdy2, rdy3, rdy4;

    mpm_qsw_pkg::slot_item_t s1_reg;
    mpm_qsw_pkg::prod_item_t s2_reg, s2_next;
    mpm_qsw_pkg::grad_item_t s3_reg, s3_next;
    mpm_qsw_pkg::out_item_t  s4_reg, s4_next;

    logic [47:0]        wprod;
    logic signed [50:0] gx_full, gy_full, gz_full;
    logic signed [51:0] sx_full, sy_full, sz_full;

    function automatic logic [31:0] sat_grad(input logic signed [35:0] v);
        logic [31:0] r;
        if (v > mpm_qsw_pkg::GRAD_MAX)
            r = mpm_qsw_pkg::GRAD_MAX[31:0];
        else if (v < mpm_qsw_pkg::GRAD_MIN)
            r = mpm_qsw_pkg::GRAD_MIN[31:0];
        else
            r = v[31:0];
        return r;
    endfunction

    // Per-stage ready: a stage moves when empty or when its successor moves
    always_comb
    begin
        rdy4 = !s4_valid_reg || !out_stall;
        rdy3 = !s3_valid_reg || rdy4;
        rdy2 = !s2_valid_reg || rdy3;
        rdy1 = !s1_valid_reg || rdy2;
        s1_valid_next = rdy1 ? in_valid : s1_valid_reg;
        s2_valid_next = rdy2 ? s1_valid_reg : s2_valid_reg;
        s3_valid_next = rdy3 ? s2_valid_reg : s3_valid_reg;
        s4_valid_next = rdy4 ? s3_valid_reg : s4_valid_reg;
    end

    assign in_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
        end
    end

    // Stage 2: weight pair products
    always_comb
    begin
        s2_next.tag  = s1_reg.tag;
        s2_next.wx   = s1_reg.wx;
        s2_next.m_yz = 32'(s1_reg.wy) * 32'(s1_reg.wz);
        s2_next.m_xz = 32'(s1_reg.wx) * 32'(s1_reg.wz);
        s2_next.m_xy = 32'(s1_reg.wx) * 32'(s1_reg.wy);
        s2_next.dx   = s1_reg.dx;
        s2_next.dy   = s1_reg.dy;
        s2_next.dz   = s1_reg.dz;
    end

    // Stage 3: triple products, floor by 2^32
    always_comb
    begin
        wprod   = 48'(s2_reg.wx) * 48'(s2_reg.m_yz);
        gx_full = 51'(s2_reg.dx) * 51'($signed({1'b0, s2_reg.m_yz}));
        gy_full = 51'(s2_reg.dy) * 51'($signed({1'b0, s2_reg.m_xz}));
        gz_full = 51'(s2_reg.dz) * 51'($signed({1'b0, s2_reg.m_xy}));

        s3_next.tag    = s2_reg.tag;
        s3_next.weight = wprod[47:32];
        s3_next.gx     = gx_full[50:32];
        s3_next.gy     = gy_full[50:32];
        s3_next.gz     = gz_full[50:32];
    end

    // Stage 4: scale by inverse cell size, floor by 2^16, saturate
    always_comb
    begin
        sx_full = 52'(s3_reg.gx) * 52'($signed({1'b0, inv_cell_size}));
        sy_full = 52'(s3_reg.gy) * 52'($signed({1'b0, inv_cell_size}));
        sz_full = 52'(s3_reg.gz) * 52'($signed({1'b0, inv_cell_size}));

        s4_next.tag    = s3_reg.tag;
        s4_next.weight = s3_reg.weight;
        s4_next.grad_x = sat_grad(sx_full[51:16]);
        s4_next.grad_y = sat_grad(sy_full[51:16]);
        s4_next.grad_z = sat_grad(sz_full[51:16]);
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_reg <= in_item;
        end
        if (rdy2)
        begin
            s2_reg <= s2_next;
        end
        if (rdy3)
        begin
            s3_reg <= s3_next;
        end
        if (rdy4)
        begin
            s4_reg <= s4_next;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_item  = s4_reg;

endmodule

// ===== test/mpm_quadratic_stencil_weights_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpm_quadratic_stencil_weights_test
// Self-checking bench for the quadratic B-spline stencil generator. Each
// particle is expected to produce 27 node entries that are predicted here
// in 64-bit fixed point and compared field by field against the output
// stream. A short table of corner particles goes first, then random
// particles under several cell scales, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module mpm_quadratic_stencil_weights_test;

    localparam logic [31:0] SCALE_AT_RESET = 32'h0001_0000;   // 1.0
    localparam longint      NODE_HI        = 64'sd8388607;
    localparam longint      NODE_LO        = -64'sd8388608;
    localparam longint      GRAD_HI        = 64'sd2147483647;
    localparam longint      GRAD_LO        = -64'sd2147483648;
    localparam longint      HALF_CELL      = 64'sh0000_0000_8000_0000;
    localparam int          CYCLE_LIMIT    = 400000;
    localparam int          RANDOM_PHASES  = 7;
    localparam int          PHASE_ITEMS    = 27;

    // One predicted node entry, same field order as the output ports
    typedef struct packed {
        logic [23:0]        owner;
        logic signed [23:0] node_x;
        logic signed [23:0] node_y;
        logic signed [23:0] node_z;
        logic [4:0]         slot;
        logic [15:0]        weight;
        logic signed [31:0] grad_x;
        logic signed [31:0] grad_y;
        logic signed [31:0] grad_z;
        logic               range_error;
        logic               last;
    } stencil_entry_t;

    typedef stencil_entry_t stencil_t [27];

    // Stimulus row: scale to run under, particle, and optional hand-worked entry
    typedef struct packed {
        logic [31:0]        scale;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [23:0]        id;
        bit                 known;
        logic [4:0]         kslot;
        logic signed [23:0] knode_x;
        logic [15:0]        kweight;
        bit                 krerr;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [31:0]        cfg_wr_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [23:0]        particle_id;
    logic               out_valid;
    logic               out_stall;
    logic [23:0]        owner_particle;
    logic signed [23:0] node_x;
    logic signed [23:0] node_y;
    logic signed [23:0] node_z;
    logic [4:0]         slot;
    logic [15:0]        weight;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic signed [31:0] grad_z;
    logic               range_error;
    logic               last;

    logic [31:0]    inv_scale;
    stencil_entry_t pending_entries [$];
    int             mismatch_count = 0;
    int             cycle_count = 0;
    bit             sender_calm = 1'b0;
    bit             drain_calm = 1'b0;

    // Corner particles; hand-worked entries only where the arithmetic is obvious
    stim_row_t directed_rows [22] = '{
        // unit scale: particle at origin (center and corner weights), then the extremes
        '{32'h0001_0000, 32'sh0, 32'sh0, 32'sh0, 24'h000000,
          1'b1, 5'd13, 24'sd0, 16'd27648, 1'b0},
        '{32'h0001_0000, 32'sh0, 32'sh0, 32'sh0, 24'hFFFFFF,
          1'b1, 5'd0, -24'sd1, 16'd128, 1'b0},
        '{32'h0001_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 24'h5A5A5A,
          1'b0, 5'd0, 24'sd0, 16'd0, 1'b0},
        '{32'h0001_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 24'hA5A5A5,
          1'b0, 5'd0, 24'sd0, 16'd0, 1'b0},
        // fraction edges around half a cell
        '{32'h0001_0000, 32'sh0000_8000, 32'sh0000_7FFF, 32'shFFFF_8000, 24'h000001,
          1'b0, 5'd0, 24'sd0, 16'd0, 1'b0},
        '{32'h0001_0000, 32'sh0001_8000, 32'shFFFE_7FFF, 32'sh0001_0000, 24'h123456,
          1'b0, 5'd0, 24'sd0, 16'd0, 1'b0},
        '{32'h0001_0000, 32'sh0003_4567, 32'shFFFC_BA99, 32'sh7FFF_8000, 24'h000002,
          1'b0, 5'd0, 24'sd0, 16'd0, 1'b0},
        // largest scale: node saturation both ways, gradient saturation
        '{32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh0, 32'sh0, 24'h000003,
          1'b1, 5'd13, 24'sh7F_FFFF, 16'd18432, 1'b1},
        '{32'hFFFF_FFFF, 32'sh8000_0000, 32'sh0, 32'sh0, 24'h000004,
          1'b1, 5'd13, 24'sh80_0000, 16'd18432, 1'b1},
        '{32'hFFFF_FFFF, 32'sh0, 32'sh0, 32'sh0, 24'h000005,
          1'b1, 5'd13, 24'sd0, 16'd27648, 1'b0},
        '{32'hFFFF_FFFF, 32'sh0000_0001, 32'shFFFF_FFFF, 32'sh7FFF_FFFF, 24'h000006,
          1'b0, 5'd0, 24'sd0, 16'd0, 1'b0},
        '{32'hFFFF_FFFF, 32'sh0000_8000, 32'shFFFF_8000, 32'sh8000_0001, 24'h00000F,
          1'b0, 5'd0, 24'sd0, 16'd0, 1'b0},
        // smallest nonzero scale: fraction near both ends of its range
        '{32'h0000_0001, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 24'h000007,
          1'b0, 5'd0, 24'sd0, 16'd0, 1'b0},
        '{32'h0000_0001, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 24'h000008,
          1'b0, 5'd0, 24'sd0, 16'd0, 1'b0},
        '{32'h0000_0001, 32'sh1234_5678, 32'sh8765_4321, 32'sh0, 24'h000009,
          1'b0, 5'd0, 24'sd0, 16'd0, 1'b0},
        // zero scale: every cell at 0, gradients vanish
        '{32'h0000_0000, 32'sh1234_5678, 32'sh7FFF_FFFF, 32'sh8000_0000, 24'h00000A,
          1'b1, 5'd13, 24'sd0, 16'd27648, 1'b0},
        '{32'h0000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 24'h00000B,
          1'b1, 5'd26, 24'sd1, 16'd128, 1'b0},
        // scale 2.0, then scale 32768
        '{32'h0002_0000, 32'sh0000_4000, 32'shFFFF_C000, 32'sh0040_0000, 24'h00000C,
          1'b0, 5'd0, 24'sd0, 16'd0, 1'b0},
        '{32'h0002_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0001, 24'h00000D,
          1'b0, 5'd0, 24'sd0, 16'd0, 1'b0},
        '{32'h8000_0000, 32'sh0000_0100, 32'shFFFF_FF00, 32'sh0001_0000, 24'h00000E,
          1'b0, 5'd0, 24'sd0, 16'd0, 1'b0},
        // scale 256: stencil straddles the node range, partial saturation
        '{32'h0100_0000, 32'sh7FFF_FFFF, 32'sh0, 32'sh0000_8000, 24'h0F0F0F,
          1'b0, 5'd0, 24'sd0, 16'd0, 1'b0},
        '{32'h0100_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 24'hF0F0F0,
          1'b0, 5'd0, 24'sd0, 16'd0, 1'b0}
    };

    mpm_quadratic_stencil_weights DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .particle_id    (particle_id),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .owner_particle (owner_particle),
        .node_x         (node_x),
        .node_y         (node_y),
        .node_z         (node_z),
        .slot           (slot),
        .weight         (weight),
        .grad_x         (grad_x),
        .grad_y         (grad_y),
        .grad_z         (grad_z),
        .range_error    (range_error),
        .last           (last)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gradient term: Q.16 product, rescaled by the cell scale, saturated
    function automatic logic [31:0] grad_term(input longint deriv, input longint wa,
                                              input longint wb, input longint scale);
        longint g;
        longint s;
        g = (deriv * wa * wb) >>> 32;
        s = (g * scale) >>> 16;
        if (s > GRAD_HI)
            s = GRAD_HI;
        else if (s < GRAD_LO)
            s = GRAD_LO;
        return 32'(s);
    endfunction

    // All 27 node entries of one particle under the given scale
    function automatic void predict_stencil(input stim_row_t r, input logic [31:0] cell_scale,
                                            output stencil_t ents);
        longint             scale;
        longint             q;
        longint             frac;
        longint             prod;
        longint             v;
        longint             base [3];
        longint             w [3][3];
        longint             d [3][3];
        longint             node [3];
        int                 offs [3];
        logic signed [31:0] coord [3];
        bit                 clipped;
        int                 k;
        coord[0] = r.px;
        coord[1] = r.py;
        coord[2] = r.pz;
        scale = {32'd0, cell_scale};
        // per axis: base cell, fraction in [0.5, 1.5), weights and derivatives
        for (int a = 0; a < 3; a++)
        begin
            q = longint'(coord[a]) * scale - HALF_CELL;
            base[a] = q >>> 32;
            frac = ((q & 64'h0000_0000_FFFF_FFFF) + HALF_CELL) >>> 16;
            w[a][0] = ((98304 - frac) * (98304 - frac)) >>> 17;
            w[a][1] = 49152 - (((frac - 65536) * (frac - 65536)) >>> 16);
            w[a][2] = ((frac - 32768) * (frac - 32768)) >>> 17;
            d[a][0] = frac - 98304;
            d[a][1] = 131072 - 2 * frac;
            d[a][2] = frac - 32768;
        end
        // walk the stencil, x fastest
        k = 0;
        for (int z = 0; z < 3; z++)
            for (int y = 0; y < 3; y++)
                for (int x = 0; x < 3; x++)
                begin
                    offs[0] = x;
                    offs[1] = y;
                    offs[2] = z;
                    clipped = 1'b0;
                    for (int a = 0; a < 3; a++)
                    begin
                        v = base[a] + offs[a];
                        if (v > NODE_HI)
                        begin
                            v = NODE_HI;
                            clipped = 1'b1;
                        end
                        else if (v < NODE_LO)
                        begin
                            v = NODE_LO;
                            clipped = 1'b1;
                        end
                        node[a] = v;
                    end
                    prod = w[0][x] * w[1][y] * w[2][z];
                    ents[k].owner       = r.id;
                    ents[k].node_x      = 24'(node[0]);
                    ents[k].node_y      = 24'(node[1]);
                    ents[k].node_z      = 24'(node[2]);
                    ents[k].slot        = 5'(k);
                    ents[k].weight      = 16'(prod >>> 32);
                    ents[k].grad_x      = grad_term(d[0][x], w[1][y], w[2][z], scale);
                    ents[k].grad_y      = grad_term(w[0][x], d[1][y], w[2][z], scale);
                    ents[k].grad_z      = grad_term(w[0][x], w[1][y], d[2][z], scale);
                    ents[k].range_error = clipped;
                    ents[k].last        = (k == 26);
                    k++;
                end
    endfunction

    function automatic string entry_text(input stencil_entry_t e);
        return $sformatf(
            "owner=%h node=(%0d,%0d,%0d) slot=%0d weight=%h grad=(%h,%h,%h) rerr=%b last=%b",
            e.owner, e.node_x, e.node_y, e.node_z, e.slot, e.weight,
            e.grad_x, e.grad_y, e.grad_z, e.range_error, e.last);
    endfunction

    // Random coordinate: full range, near origin, near half-cell edges, near extremes
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
            2: return ($urandom & 32'hFFFF_8000) + 32'($urandom_range(0, 3)) - 32'd2;
            default:
                if ($urandom_range(0, 1) == 0)
                    return 32'h7FFF_FFFF - 32'($urandom_range(0, 255));
                else
                    return 32'h8000_0000 + 32'($urandom_range(0, 255));
        endcase
    endfunction

    // Scale write: only with nothing in flight
    task automatic set_scale(input logic [31:0] value);
        in_valid <= 1'b0;
        while (pending_entries.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        inv_scale = value;
    endtask

    // One particle transfer; expected entries are queued on acceptance
    task automatic send_particle(input stim_row_t r);
        int       gap;
        stencil_t ents;
        if (r.scale != inv_scale)
            set_scale(r.scale);
        gap = sender_calm ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        pos_x       <= r.px;
        pos_y       <= r.py;
        pos_z       <= r.pz;
        particle_id <= r.id;
        do
            @(posedge clk);
        while (in_stall);
        predict_stencil(r, inv_scale, ents);
        // hand-worked node_x, weight and range_error replace the predicted ones
        if (r.known)
        begin
            ents[r.kslot].node_x      = r.knode_x;
            ents[r.kslot].weight      = r.kweight;
            ents[r.kslot].range_error = r.krerr;
        end
        foreach (ents[i])
            pending_entries = {pending_entries, ents[i]};
    endtask

    // Output stall: a fresh hold per result, with calm stretches
    initial
    begin
        int hold;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 63) == 0)
                drain_calm = !drain_calm;
            hold = drain_calm ? 0 : $urandom_range(0, 11);
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    // Result check against the oldest expected entry
    always @(posedge clk)
    begin : result_check
        stencil_entry_t got;
        stencil_entry_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {owner_particle, node_x, node_y, node_z, slot, weight,
                   grad_x, grad_y, grad_z, range_error, last};
            if (pending_entries.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected entry: %s", entry_text(got));
                mismatch_count++;
            end
            else
            begin
                want = pending_entries.pop_front();
                if (got !== want)
                begin
                    if (mismatch_count < 10)
                        $display("entry mismatch\n  expected %s\n  actual   %s",
                                 entry_text(want), entry_text(got));
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        stim_row_t   row;
        logic [31:0] phase_scale;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 32'd0;
        in_valid    = 1'b0;
        pos_x       = 32'sd0;
        pos_y       = 32'sd0;
        pos_z       = 32'sd0;
        particle_id = 24'd0;
        inv_scale   = SCALE_AT_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        foreach (directed_rows[i])
            send_particle(directed_rows[i]);

        // random particles, one scale per phase
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase % 5)
                0:       phase_scale = SCALE_AT_RESET;
                1:       phase_scale = 32'($urandom_range(1, 32'h0004_0000));
                2:       phase_scale = $urandom | 32'h1;
                3:       phase_scale = 32'hFFFF_FFFF;
                default: phase_scale = 32'($urandom_range(1, 32'h0000_1000));
            endcase
            sender_calm = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                row       = '0;
                row.scale = phase_scale;
                row.px    = pick_coord();
                row.py    = pick_coord();
                row.pz    = pick_coord();
                row.id    = 24'($urandom);
                send_particle(row);
            end
        end

        // drain
        in_valid <= 1'b0;
        while (pending_entries.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
